@@ sv/snrv_pkg.sv @@
// Shared types, widths and pipeline step functions for the refraction pipeline.
`default_nettype none
package snrv_pkg;

    localparam int COMP_W      = 16;
    localparam int COMP_FRAC   = 14;
    localparam int IDX_W       = 16;
    localparam int DOT_W       = 2 * COMP_W + 2;
    localparam int C1_SHIFT    = 2 * COMP_FRAC - 16;
    localparam int C1_W        = 20;
    localparam int ETA_W       = 32;
    localparam int ETA2_W      = 2 * ETA_W;
    localparam int C1SQ_W      = 2 * C1_W;
    localparam int EC_W        = ETA_W + C1_W;
    localparam int DIFF_W      = C1SQ_W;
    localparam int PP_W        = ETA_W + DIFF_W;
    localparam int P_W         = 105;
    localparam int RAD_W       = 106;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SREM_W      = ROOT_W + 3;
    localparam int K_W         = 55;
    localparam int EV_W        = ETA_W + 1 + COMP_W;
    localparam int KN_W        = K_W + COMP_W;
    localparam int SUM_W       = 72;
    localparam int Q_W         = SUM_W - 32;
    localparam int DIV_PER     = 2;
    localparam int DIV_STAGES  = ETA_W / DIV_PER;
    localparam int SQRT_STAGES = ROOT_W;

    localparam logic [DOT_W-1:0]  DOT_HALF = DOT_W'(1) << (C1_SHIFT - 1);
    localparam logic [C1SQ_W-1:0] ONE32    = C1SQ_W'(1) << 32;
    localparam logic [P_W-1:0]    ONE64    = P_W'(1) << 64;
    localparam logic [SUM_W-1:0]  Q_HALF   = SUM_W'(1) << 31;

    typedef logic signed [COMP_W-1:0]  t_comp;
    typedef logic signed [2*COMP_W-1:0] t_prod;
    typedef logic signed [EV_W-1:0]    t_ev;
    typedef logic signed [KN_W-1:0]    t_kn;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [SUM_W-1:0]          t_mag;

    typedef struct packed {
        t_comp [2:0]              v;
        t_comp [2:0]              n;
        logic [IDX_W-1:0]         n2;
        logic                     tir;
        t_prod [2:0]              prod;
        logic signed [DOT_W-1:0]  dot;
        logic [C1_W-1:0]          c1;
        logic                     c1neg;
        logic [ETA_W-1:0]         dnd;
        logic [IDX_W-1:0]         drem;
        logic [ETA_W-1:0]         quo;
        logic [ETA_W-1:0]         eta;
        logic [ETA2_W-1:0]        eta2;
        logic [C1SQ_W-1:0]        c1sq;
        logic [EC_W-1:0]          ec;
        logic [DIFF_W-1:0]        diff;
        logic                     dneg;
        logic [PP_W-1:0]          ph;
        logic [PP_W-1:0]          pl;
        logic [P_W-1:0]           p;
        logic [RAD_W-1:0]         rad;
        logic [SREM_W-1:0]        srem;
        logic [ROOT_W-1:0]        root;
        logic signed [K_W-1:0]    k;
        t_ev [2:0]                ev;
        t_kn [2:0]                kn;
        t_sum [2:0]               sum;
        t_mag [2:0]               mag;
        logic [2:0]               neg;
    } t_ctx;

    // restoring division, DIV_PER quotient bits
    function automatic t_ctx div_step(t_ctx c);
        t_ctx r;
        logic [IDX_W:0] t;
        r = c;
        for (int j = 0; j < DIV_PER; j++) begin
            t     = {r.drem, r.dnd[ETA_W-1]};
            r.dnd = {r.dnd[ETA_W-2:0], 1'b0};
            if (t >= {1'b0, r.n2}) begin
                r.drem = IDX_W'(t - {1'b0, r.n2});
                r.quo  = {r.quo[ETA_W-2:0], 1'b1};
            end else begin
                r.drem = t[IDX_W-1:0];
                r.quo  = {r.quo[ETA_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // one root bit per step, two radicand bits consumed
    function automatic t_ctx sqrt_step(t_ctx c);
        t_ctx r;
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        r     = c;
        t     = {r.srem, r.rad[RAD_W-1:RAD_W-2]};
        trial = (SREM_W+2)'({r.root, 2'b01});
        r.rad = {r.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            r.srem = SREM_W'(t - trial);
            r.root = {r.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.srem = t[SREM_W-1:0];
            r.root = {r.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/snell_refraction_vector.sv @@
// Snell refraction of a direction vector, pipelined from input beat to result.
// Throughput one beat per cycle unless the output stalls; the depth is set by the
// 16-stage divider (2 bits/stage) and the 53-stage square root (1 bit/stage).
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`default_nettype none
module snell_refraction_vector import snrv_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_from, index_to
    input  wire logic [127:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_x, out_y, out_z
    output logic [47:0]       o_m_axis_tdata,
    // transmitted
    output logic [0:0]        o_m_axis_tuser
);

    logic en;
    t_ctx r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h, r_i, r_j, r_k, r_l, r_m;
    t_ctx n_a, n_b, n_c, n_d, n_e, n_f, n_g, n_h, n_i, n_j, n_k, n_l, n_m;
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    logic r_vj, r_vk, r_vl, r_vm;
    logic div_vld, sqrt_vld;
    t_ctx div_ctx, sqrt_ctx;
    logic [47:0] n_out_data;
    logic        r_out_vld;
    logic [47:0] r_out_data;
    logic        r_out_tr;

    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_comb begin
        logic [IDX_W-1:0] n1;
        n_a = '0;
        for (int i = 0; i < 3; i++) begin
            n_a.v[i] = i_s_axis_tdata[16*i +: 16];
            n_a.n[i] = i_s_axis_tdata[48 + 16*i +: 16];
        end
        n1      = i_s_axis_tdata[111:96];
        n_a.n2  = i_s_axis_tdata[127:112];
        n_a.tir = (n_a.n2 == '0);
        n_a.dnd = {n1, 16'b0};
    end

    always_comb begin
        n_b = r_a;
        for (int i = 0; i < 3; i++) begin
            n_b.prod[i] = $signed(r_a.v[i]) * $signed(r_a.n[i]);
        end
    end

    always_comb begin
        n_c = r_b;
        n_c.dot = DOT_W'($signed(r_b.prod[0])) + DOT_W'($signed(r_b.prod[1]))
                + DOT_W'($signed(r_b.prod[2]));
    end

    // c1 = -dot rounded half away from zero to Q.16
    always_comb begin
        logic [DOT_W-1:0] dmag;
        logic [DOT_W-1:0] rnd;
        n_d = r_c;
        dmag = r_c.dot[DOT_W-1] ? DOT_W'(-r_c.dot) : DOT_W'(r_c.dot);
        rnd  = dmag + DOT_HALF;
        n_d.c1    = C1_W'(rnd >> C1_SHIFT);
        n_d.c1neg = !r_c.dot[DOT_W-1] && (r_c.dot != '0);
    end

    snrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vd),
        .i_ctx   (r_d),
        .o_vld   (div_vld),
        .o_ctx   (div_ctx)
    );

    always_comb begin
        n_e = div_ctx;
        n_e.eta  = div_ctx.quo;
        n_e.eta2 = div_ctx.quo * div_ctx.quo;
        n_e.c1sq = div_ctx.c1 * div_ctx.c1;
        n_e.ec   = div_ctx.quo * div_ctx.c1;
    end

    always_comb begin
        n_f = r_e;
        if (r_e.c1sq < ONE32) begin
            n_f.dneg = 1'b1;
            n_f.diff = ONE32 - r_e.c1sq;
        end else begin
            n_f.dneg = 1'b0;
            n_f.diff = r_e.c1sq - ONE32;
        end
    end

    always_comb begin
        n_g = r_f;
        n_g.ph = r_f.eta2[ETA2_W-1:32] * r_f.diff;
        n_g.pl = r_f.eta2[31:0] * r_f.diff;
    end

    always_comb begin
        n_h = r_g;
        n_h.p = P_W'({r_g.ph, 32'b0}) + P_W'(r_g.pl);
    end

    // cs2 = 1 - eta^2 (1 - c1^2); reflection when it goes negative
    always_comb begin
        n_i = r_h;
        if (r_h.dneg) begin
            n_i.tir = r_h.tir || (r_h.p > ONE64);
            n_i.rad = RAD_W'(ONE64 - r_h.p);
        end else begin
            n_i.rad = RAD_W'(ONE64 + r_h.p);
        end
        n_i.srem = '0;
        n_i.root = '0;
    end

    snrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vi),
        .i_ctx   (r_i),
        .o_vld   (sqrt_vld),
        .o_ctx   (sqrt_ctx)
    );

    always_comb begin
        logic signed [K_W-1:0] sec;
        n_j = sqrt_ctx;
        sec = sqrt_ctx.c1neg ? -$signed(K_W'(sqrt_ctx.ec)) : $signed(K_W'(sqrt_ctx.ec));
        n_j.k = sec - $signed(K_W'(sqrt_ctx.root));
    end

    always_comb begin
        n_k = r_j;
        for (int i = 0; i < 3; i++) begin
            n_k.ev[i] = $signed({1'b0, r_j.eta}) * $signed(r_j.v[i]);
            n_k.kn[i] = $signed(r_j.k) * $signed(r_j.n[i]);
        end
    end

    always_comb begin
        n_l = r_k;
        for (int i = 0; i < 3; i++) begin
            n_l.sum[i] = $signed({{7{r_k.ev[i][EV_W-1]}}, r_k.ev[i], 16'b0})
                       + $signed({r_k.kn[i][KN_W-1], r_k.kn[i]});
        end
    end

    always_comb begin
        n_m = r_l;
        for (int i = 0; i < 3; i++) begin
            n_m.neg[i] = r_l.sum[i][SUM_W-1];
            n_m.mag[i] = r_l.sum[i][SUM_W-1] ? SUM_W'(-r_l.sum[i]) : SUM_W'(r_l.sum[i]);
        end
    end

    // round half away from zero, saturate, zero on reflection
    always_comb begin
        logic [SUM_W-1:0] rs;
        logic [Q_W-1:0]   q;
        logic [15:0]      f;
        n_out_data = '0;
        for (int i = 0; i < 3; i++) begin
            rs = r_m.mag[i] + Q_HALF;
            q  = rs[SUM_W-1:32];
            if (r_m.neg[i]) begin
                f = (q > Q_W'(32768)) ? 16'h8000 : 16'(16'd0 - q[15:0]);
            end else begin
                f = (q > Q_W'(32767)) ? 16'h7fff : q[15:0];
            end
            n_out_data[16*i +: 16] = r_m.tir ? 16'd0 : f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0;
            r_ve <= 1'b0; r_vf <= 1'b0; r_vg <= 1'b0; r_vh <= 1'b0; r_vi <= 1'b0;
            r_vj <= 1'b0; r_vk <= 1'b0; r_vl <= 1'b0; r_vm <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_va <= i_s_axis_tvalid;
            r_vb <= r_va; r_vc <= r_vb; r_vd <= r_vc;
            r_ve <= div_vld; r_vf <= r_ve; r_vg <= r_vf; r_vh <= r_vg; r_vi <= r_vh;
            r_vj <= sqrt_vld; r_vk <= r_vj; r_vl <= r_vk; r_vm <= r_vl;
            r_out_vld <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
            r_e <= n_e; r_f <= n_f; r_g <= n_g; r_h <= n_h; r_i <= n_i;
            r_j <= n_j; r_k <= n_k; r_l <= n_l; r_m <= n_m;
            r_out_data <= n_out_data;
            r_out_tr   <= !r_m.tir;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_tr;

endmodule
`default_nettype wire

@@ sv/snrv_div.sv @@
// Pipelined restoring divider for eta = (index_from << 16) / index_to.
`default_nettype none
module snrv_div import snrv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_ctx i_ctx,
    output logic      o_vld,
    output t_ctx      o_ctx
);

    t_ctx                  r_ctx [DIV_STAGES];
    t_ctx                  n_ctx [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;

    always_comb begin
        n_ctx[0] = div_step(i_ctx);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_ctx[s] = div_step(r_ctx[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_ctx[s] <= n_ctx[s];
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_ctx = r_ctx[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ sv/snrv_sqrt.sv @@
// Pipelined digit-by-digit integer square root of cs2, one root bit per stage.
`default_nettype none
module snrv_sqrt import snrv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_ctx i_ctx,
    output logic      o_vld,
    output t_ctx      o_ctx
);

    t_ctx                   r_ctx [SQRT_STAGES];
    t_ctx                   n_ctx [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] r_vld;

    always_comb begin
        n_ctx[0] = sqrt_step(i_ctx);
        for (int s = 1; s < SQRT_STAGES; s++) begin
            n_ctx[s] = sqrt_step(r_ctx[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_ctx[s] <= n_ctx[s];
            end
        end
    end

    assign o_vld = r_vld[SQRT_STAGES-1];
    assign o_ctx = r_ctx[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ verif/tb_snell_refraction_vector.sv @@
// Self-checking testbench for the Snell refraction vector pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_snell_refraction_vector import snrv_pkg::*;;

    typedef logic signed [159:0] t_wide;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        transmitted;
    } t_ray;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [47:0]  o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;

    logic [127:0] ray_q[$];
    t_ray         refracted_q[$];
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int           n_mismatch;
    int           quiet_cycles;
    int           hold_cnt;
    logic         hold_req;

    snell_refraction_vector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // exact integer square root, floor
    function automatic t_wide isqrt(t_wide x);
        t_wide res;
        t_wide c;
        res = 0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (t_wide'(1) <<< b);
            if (c * c <= x) res = c;
        end
        return res;
    endfunction

    // round half away from zero to the component grid, then saturate
    function automatic logic [15:0] to_comp(t_wide r);
        t_wide mag;
        t_wide q;
        mag = (r < 0) ? -r : r;
        q = (mag + (t_wide'(1) <<< 31)) >>> 32;
        if (r >= 0) return (q > 32767) ? 16'sd32767 : q[15:0];
        if (q > 32768) q = 32768;
        return 16'((-q));
    endfunction

    function automatic t_ray refract(logic [127:0] d);
        t_ray  res;
        t_wide v[3];
        t_wide n[3];
        t_wide dot;
        t_wide eta;
        t_wide dmag;
        t_wide c1m;
        t_wide c1s;
        t_wide cs2;
        t_wide root;
        t_wide k;
        logic [15:0] n1;
        logic [15:0] n2;
        res = '0;
        n1 = d[111:96];
        n2 = d[127:112];
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = $signed(d[16*i +: 16]);
            n[i] = $signed(d[48 + 16*i +: 16]);
            dot += v[i] * n[i];
        end
        if (n2 == 0) return res;
        eta = (t_wide'(n1) <<< 16) / t_wide'(n2);
        dmag = (dot < 0) ? -dot : dot;
        c1m = (dmag + (1 <<< (C1_SHIFT - 1))) >>> C1_SHIFT;
        c1s = (dot > 0) ? -c1m : c1m;
        cs2 = (t_wide'(1) <<< 64) - eta * eta * ((t_wide'(1) <<< 32) - c1m * c1m);
        if (cs2 < 0) return res;
        root = isqrt(cs2);
        k = eta * c1s - root;
        res.x = to_comp(((eta * v[0]) <<< 16) + k * n[0]);
        res.y = to_comp(((eta * v[1]) <<< 16) + k * n[1]);
        res.z = to_comp(((eta * v[2]) <<< 16) + k * n[2]);
        res.transmitted = 1'b1;
        return res;
    endfunction

    function automatic logic [127:0] pack_ray(int vx, int vy, int vz, int nx, int ny, int nz,
                                              int n1, int n2);
        return {16'(n2), 16'(n1), 16'(nz), 16'(ny), 16'(nx), 16'(vz), 16'(vy), 16'(vx)};
    endfunction

    function automatic logic [127:0] random_ray();
        logic [127:0] d;
        int sel;
        d = {$urandom, $urandom, $urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 60) begin
            // components within +/-1.0 with indices near common media
            for (int i = 0; i < 6; i++) d[16*i +: 16] = 16'($urandom_range(32768) - 16384);
            d[111:96]  = 16'($urandom_range(9000, 3000));
            d[127:112] = 16'($urandom_range(9000, 3000));
        end else if (sel < 64) begin
            d[127:112] = '0;
        end else if (sel < 68) begin
            d[111:96] = '0;
        end
        return d;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) refracted_q.push_back(refract(i_s_axis_tdata));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (ray_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_s_axis_tdata  <= ray_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) hold_cnt <= 0;
        else if (hold_req) hold_cnt <= 400;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_ray got;
        t_ray want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[15:0], o_m_axis_tdata[31:16], o_m_axis_tdata[47:32],
                       o_m_axis_tuser[0]};
                if (refracted_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected beat: x=%h y=%h z=%h t=%b",
                                                   got.x, got.y, got.z, got.transmitted);
                end else begin
                    want = refracted_q.pop_front();
                    if (got.x != want.x || got.y != want.y || got.z != want.z ||
                        got.transmitted != want.transmitted) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("beat mismatch: exp x=%h y=%h z=%h t=%b got x=%h y=%h z=%h t=%b",
                                     want.x, want.y, want.z, want.transmitted,
                                     got.x, got.y, got.z, got.transmitted);
                    end
                end
            end
            i_m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on stalled traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000 && (ray_q.size() > 0 || refracted_q.size() > 0 ||
                                         i_s_axis_tvalid)) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic drain();
        wait (ray_q.size() == 0 && !i_s_axis_tvalid && refracted_q.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 65, 0, 36};
        stall_tab = '{0, 0, 65, 36};
        hold_req = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        ray_q.push_back(pack_ray(0, 0, 0, 0, 0, 0, 4096, 4096));
        ray_q.push_back(pack_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535, 65535));
        ray_q.push_back(pack_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 1));
        ray_q.push_back(pack_ray(-32768, -32768, -32768, 32767, 32767, 32767, 1, 65535));
        ray_q.push_back(pack_ray(0, 0, -16384, 0, 0, 16384, 4096, 6144));     // head-on
        ray_q.push_back(pack_ray(11585, 0, -11585, 0, 0, 16384, 6144, 4096)); // 45 deg into rarer
        ray_q.push_back(pack_ray(16000, 0, -3000, 0, 0, 16384, 8192, 4096));  // grazing, reflects
        ray_q.push_back(pack_ray(16384, 0, 0, 0, 16384, 0, 4096, 4096));      // critical angle
        ray_q.push_back(pack_ray(1000, 2000, 3000, 100, 200, 300, 4096, 0));  // no index_to
        ray_q.push_back(pack_ray(1000, -2000, 3000, -100, 16384, 300, 0, 4096)); // no index_from
        ray_q.push_back(pack_ray(32767, -32768, 0, 32767, 32767, 0, 12288, 4096));
        ray_q.push_back(pack_ray(-32768, 0, 0, -32768, 0, 0, 65535, 1));
        ray_q.push_back(pack_ray(1, 0, 0, 1, 0, 0, 1, 1));
        ray_q.push_back(pack_ray(2048, 0, 0, 1, 0, 0, 4096, 4096));          // dot on a half step
        ray_q.push_back(pack_ray(-2048, 0, 0, 1, 0, 0, 4096, 4096));
        ray_q.push_back(pack_ray(0, 32767, 0, 0, -32768, 0, 65535, 65535));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_tab[ph];
            receiver_stall_pct = stall_tab[ph];
            for (int i = 0; i < 170; i++) ray_q.push_back(random_ray());
            if (ph == 0) begin
                @(negedge i_clk) hold_req = 1'b1;
                @(negedge i_clk) hold_req = 1'b0;
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (n_mismatch == 0 && refracted_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
sv/snrv_pkg.sv
sv/snrv_div.sv
sv/snrv_sqrt.sv
sv/snell_refraction_vector.sv
verif/tb_snell_refraction_vector.sv
